@@ hdl/admission_credit_controller_assert.svh @@
// assertion macros for the admission credit controller
`ifndef ADMISSION_CREDIT_CONTROLLER_ASSERT_SVH
`define ADMISSION_CREDIT_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ACC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ACC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/acc_pkg.sv @@
// shared types and constants of the admission credit controller
`default_nettype none

package acc_pkg;

    localparam int TASK_BITS_DEF  = 32;
    localparam int BYTE_BITS_DEF  = 48;
    localparam int REQ_TYPE_BITS  = 2;
    localparam int STATUS_BITS    = 3;
    localparam int CFG_INDEX_BITS = 1;

    typedef enum logic [REQ_TYPE_BITS-1:0] {
        REQ_RESERVE = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_CLOSE   = 2'd2
    } req_kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_FAILED    = 3'd2,
        ST_CLOSED    = 3'd3,
        ST_LIMIT     = 3'd4,
        ST_UNDERFLOW = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MAX_TASKS = 1'd0,
        CFG_MAX_BYTES = 1'd1
    } cfg_index_t;

endpackage

`default_nettype wire

@@ hdl/acc_if.sv @@
// request, result and configuration channels of the admission credit controller
`default_nettype none

interface acc_req_if
    import acc_pkg::*;
#(
    parameter int TASK_BITS = TASK_BITS_DEF,
    parameter int BYTE_BITS = BYTE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_BITS-1:0] req_type;
    logic [TASK_BITS-1:0]     task_amount;
    logic [BYTE_BITS-1:0]     byte_amount;

    modport source (output valid, req_type, task_amount, byte_amount, input ready);
    modport sink   (input valid, req_type, task_amount, byte_amount, output ready);
endinterface

interface acc_rsp_if
    import acc_pkg::*;
#(
    parameter int TASK_BITS = TASK_BITS_DEF,
    parameter int BYTE_BITS = BYTE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [TASK_BITS-1:0]   outstanding_tasks;
    logic [BYTE_BITS-1:0]   outstanding_bytes;
    logic                   failed_flag;
    logic                   drained;

    modport source (output valid, status, outstanding_tasks, outstanding_bytes,
                    failed_flag, drained, input ready);
    modport sink   (input valid, status, outstanding_tasks, outstanding_bytes,
                    failed_flag, drained, output ready);
endinterface

interface acc_cfg_if
    import acc_pkg::*;
#(
    parameter int DATA_BITS = BYTE_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/admission_credit_controller.sv @@
// admission credit controller top level: task and byte credit accounting
//
// channel  role    carries
// -------  ------  ----------------------------------------------------------
// req      sink    req_type, task_amount, byte_amount
// rsp      source  status, outstanding_tasks, outstanding_bytes, failed_flag, drained
// cfg      sink    index (0 max_tasks, 1 max_bytes), data
//
// one request per cycle sustained while results are taken; each request passes
// through the input register and then the result register
// the counter update (add or subtract plus limit compare) is combinational
// rst_n clears counters, opens the gate, clears failure and sets both limits to all ones
// a stalled result holds the result register; the input register still drains
// into it in the cycle the result is taken, so no bubble is inserted
// cfg is always ready; user writes it only while no request is in flight, unenforced
`default_nettype none

`include "admission_credit_controller_assert.svh"

module admission_credit_controller
    import acc_pkg::*;
#(
    parameter int TASK_BITS = TASK_BITS_DEF,
    parameter int BYTE_BITS = BYTE_BITS_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    acc_req_if.sink   req,
    acc_rsp_if.source rsp,
    acc_cfg_if.sink   cfg
);

    // input register
    logic                     in_valid_reg;
    logic [REQ_TYPE_BITS-1:0] in_type_reg;
    logic [TASK_BITS-1:0]     in_tasks_reg;
    logic [BYTE_BITS-1:0]     in_bytes_reg;

    // limits and accounting state
    logic [TASK_BITS-1:0]     max_tasks_reg;
    logic [BYTE_BITS-1:0]     max_bytes_reg;
    logic [TASK_BITS-1:0]     task_count_reg;
    logic [TASK_BITS-1:0]     task_count_next;
    logic [BYTE_BITS-1:0]     byte_count_reg;
    logic [BYTE_BITS-1:0]     byte_count_next;
    logic                     accepting_reg;
    logic                     accepting_next;
    logic                     failure_reg;
    logic                     failure_next;

    // result register
    logic                     out_valid_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;
    logic [TASK_BITS-1:0]     out_tasks_reg;
    logic [BYTE_BITS-1:0]     out_bytes_reg;
    logic                     out_failed_reg;
    logic                     out_drained_reg;

    logic                     advance;
    logic                     in_ready;
    req_kind_t                kind;
    status_t                  status_next;
    logic [TASK_BITS:0]       task_sum;
    logic [BYTE_BITS:0]       byte_sum;
    logic                     over_limit;
    logic                     under_flow;
    logic                     zero_amount;

    // request moves into the result register when that register is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign in_ready = !in_valid_reg || advance;

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    assign kind = req_kind_t'(in_type_reg);

    // one extra bit on the sums makes the limit check safe against wrap
    assign task_sum = {1'b0, task_count_reg} + {1'b0, in_tasks_reg};
    assign byte_sum = {1'b0, byte_count_reg} + {1'b0, in_bytes_reg};

    assign over_limit  = (task_sum > {1'b0, max_tasks_reg})
                      || (byte_sum > {1'b0, max_bytes_reg});
    assign under_flow  = (in_tasks_reg > task_count_reg) || (in_bytes_reg > byte_count_reg);
    assign zero_amount = (in_tasks_reg == '0) || (in_bytes_reg == '0);

    // request evaluation against the current accounting state
    always_comb
    begin
        status_next     = ST_OK;
        task_count_next = task_count_reg;
        byte_count_next = byte_count_reg;
        accepting_next  = accepting_reg;
        failure_next    = failure_reg;
        case (kind)
            REQ_RESERVE:
            begin
                if (zero_amount)
                begin
                    status_next = ST_ZERO;
                end
                else if (failure_reg)
                begin
                    status_next = ST_FAILED;
                end
                else if (!accepting_reg)
                begin
                    status_next = ST_CLOSED;
                end
                else if (over_limit)
                begin
                    status_next = ST_LIMIT;
                end
                else
                begin
                    task_count_next = task_sum[TASK_BITS-1:0];
                    byte_count_next = byte_sum[BYTE_BITS-1:0];
                end
            end
            REQ_RELEASE:
            begin
                // release ignores the gate and the failure flag
                if (under_flow)
                begin
                    status_next  = ST_UNDERFLOW;
                    failure_next = 1'b1;
                end
                else
                begin
                    task_count_next = task_count_reg - in_tasks_reg;
                    byte_count_next = byte_count_reg - in_bytes_reg;
                end
            end
            REQ_CLOSE:
            begin
                accepting_next = 1'b0;
            end
            default:
            begin
                // unused request type: report ok, touch nothing
                status_next = ST_OK;
            end
        endcase
    end

    // control state, limits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_tasks_reg  <= '1;
            max_bytes_reg  <= '1;
            task_count_reg <= '0;
            byte_count_reg <= '0;
            accepting_reg  <= 1'b1;
            failure_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                task_count_reg <= task_count_next;
                byte_count_reg <= byte_count_next;
                accepting_reg  <= accepting_next;
                failure_reg    <= failure_next;
            end
            // limit writes, index out of the list is dropped
            if (cfg.valid)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_MAX_TASKS: max_tasks_reg <= cfg.data[TASK_BITS-1:0];
                    CFG_MAX_BYTES: max_bytes_reg <= cfg.data[BYTE_BITS-1:0];
                    default:       max_tasks_reg <= max_tasks_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && in_ready)
        begin
            in_type_reg  <= req.req_type;
            in_tasks_reg <= req.task_amount;
            in_bytes_reg <= req.byte_amount;
        end
        if (advance)
        begin
            out_status_reg  <= status_next;
            out_tasks_reg   <= task_count_next;
            out_bytes_reg   <= byte_count_next;
            out_failed_reg  <= failure_next;
            out_drained_reg <= (task_count_next == '0) && (byte_count_next == '0);
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.outstanding_tasks = out_tasks_reg;
    assign rsp.outstanding_bytes = out_bytes_reg;
    assign rsp.failed_flag       = out_failed_reg;
    assign rsp.drained           = out_drained_reg;

    // failure is sticky until reset
    `ACC_ASSERT_NEXT(a_failure_sticky, failure_reg, failure_reg, "failure flag cleared")

    // a closed gate never reopens
    `ACC_ASSERT_NEXT(a_gate_stays_closed, !accepting_reg, !accepting_reg, "admission reopened")

    // an admitted reservation grows the task counter by its amount
    `ACC_ASSERT_NEXT(a_reserve_adds,
        advance && (kind == REQ_RESERVE) && (status_next == ST_OK),
        task_count_reg == $past(task_sum[TASK_BITS-1:0]),
        "task counter not advanced by reserved amount")

    // a result is produced for every request that leaves the input register
    `ACC_ASSERT_NEXT(a_result_follows, advance, out_valid_reg, "result lost")

endmodule

`default_nettype wire
